/* src/markdown_block_splitter_defines.svh */
// Assertion macros shared by the markdown block splitter RTL.
// Files that assert include this header; the macros expect clk and rst_n in scope.
`ifndef MARKDOWN_BLOCK_SPLITTER_DEFINES_SVH
`define MARKDOWN_BLOCK_SPLITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("markdown_block_splitter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("markdown_block_splitter: next-cycle check failed");

`endif

/* src/mbs_pkg.sv */
// Package for the markdown block splitter: payload structs, line flags,
// scan mode encoding and character constants. No dependencies.
package mbs_pkg;

    localparam int OFFSET_WIDTH_DEFAULT = 32;
    localparam int OUT_WIDTH            = 32;

    localparam logic [7:0] CHAR_BACKTICK = 8'h60;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_NL       = 8'h0A;

    localparam logic [1:0] FENCE_TICKS = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_PLAIN = 3'b010,
        MODE_FENCE = 3'b100
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] block_start;
        logic [OUT_WIDTH-1:0] block_end;
    } block_item_t;

    // Per-line classification flags, updated byte by byte.
    typedef struct packed {
        logic       all_blank;
        logic [1:0] ticks;
        logic       prefix_ok;
        logic       tail_white;
    } line_flags_t;

    localparam line_flags_t LINE_FLAGS_CLEAR = '{
        all_blank:  1'b1,
        ticks:      2'd0,
        prefix_ok:  1'b1,
        tail_white: 1'b1
    };

endpackage

/* src/markdown_block_splitter.sv */
// Top level of the markdown block splitter: scan state registers and the
// result register. Depends on mbs_pkg, mbs_scan_core and the assertion header.
//
//   Channel   Direction  Handshake                 Payload
//   byte_*    in         byte_valid / byte_ready   byte_data  (byte_item_t)
//   block_*   out        block_valid / block_ready block_data (block_item_t)
//
// One byte is taken per cycle while byte_ready is high; its block, if it
// closes one, appears in the result register on the next cycle.
// The only throughput limit is the single result register: a byte is refused
// only while a finished block waits there and block_ready is low.
// rst_n clears all scan state and empties the result register asynchronously.
// A transfer with last_byte set returns the scan state to its reset values,
// so the following byte starts a new body at offset 0.
`include "markdown_block_splitter_defines.svh"

module markdown_block_splitter
    import mbs_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  byte_item_t  byte_data,
    output logic        block_valid,
    input  logic        block_ready,
    output block_item_t block_data
);

    // Scan state: one register per field of the line/block tracker.
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] line_begin_reg;
    logic [OFFSET_WIDTH-1:0] open_start_reg;
    logic [OFFSET_WIDTH-1:0] last_end_reg;
    scan_mode_t              mode_reg;
    line_flags_t             flags_reg;

    logic [OFFSET_WIDTH-1:0] pos_next;
    logic [OFFSET_WIDTH-1:0] line_begin_next;
    logic [OFFSET_WIDTH-1:0] open_start_next;
    logic [OFFSET_WIDTH-1:0] last_end_next;
    scan_mode_t              mode_next;
    line_flags_t             flags_next;

    // Result register holding at most one finished block.
    logic        block_valid_reg;
    block_item_t block_data_reg;

    logic        emit;
    block_item_t emit_item;
    logic        byte_xfer;

    // The result register frees up in the same cycle that its block is taken,
    // so while block_ready is high the stream keeps moving at one byte per cycle.
    assign byte_ready = !block_valid_reg || block_ready;
    assign byte_xfer  = byte_valid && byte_ready;

    mbs_scan_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_scan_core (
        .item            (byte_data),
        .pos             (pos_reg),
        .line_begin      (line_begin_reg),
        .open_start      (open_start_reg),
        .last_end        (last_end_reg),
        .mode            (mode_reg),
        .flags           (flags_reg),
        .pos_next        (pos_next),
        .line_begin_next (line_begin_next),
        .open_start_next (open_start_next),
        .last_end_next   (last_end_next),
        .mode_next       (mode_next),
        .flags_next      (flags_next),
        .emit            (emit),
        .emit_item       (emit_item)
    );

    // Scan state advances only on an accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            line_begin_reg <= '0;
            open_start_reg <= '0;
            last_end_reg   <= '0;
            mode_reg       <= MODE_IDLE;
            flags_reg      <= LINE_FLAGS_CLEAR;
        end
        else if (byte_xfer)
        begin
            pos_reg        <= pos_next;
            line_begin_reg <= line_begin_next;
            open_start_reg <= open_start_next;
            last_end_reg   <= last_end_next;
            mode_reg       <= mode_next;
            flags_reg      <= flags_next;
        end
    end

    // A new block overwrites the register only when it is empty or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_valid_reg <= 1'b0;
        end
        else if (byte_xfer && emit)
        begin
            block_valid_reg <= 1'b1;
        end
        else if (block_ready)
        begin
            block_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_xfer && emit)
        begin
            block_data_reg <= emit_item;
        end
    end

    assign block_valid = block_valid_reg;
    assign block_data  = block_data_reg;

    // A block that closes on an accepted byte must be presented next cycle.
    `MBS_ASSERT_NEXT(a_emit_presented, byte_xfer && emit, block_valid_reg)

    // The final byte of a body rewinds the offset counter and the mode.
    `MBS_ASSERT_NEXT(a_last_rewinds, byte_xfer && byte_data.last_byte,
                     (pos_reg == '0) && (mode_reg == MODE_IDLE))

    // Blocks never end before they start.
    `MBS_ASSERT_NOW(a_block_ordered, block_valid_reg,
                    block_data_reg.block_start <= block_data_reg.block_end)

    // Bytes inside a line leave the recorded line start alone.
    `MBS_ASSERT_NEXT(a_line_begin_holds,
                     byte_xfer && !byte_data.last_byte && (byte_data.byte_value != CHAR_NL),
                     line_begin_reg == $past(line_begin_reg))

endmodule

/* src/mbs_scan_core.sv */
// Next-state and result logic of the markdown block splitter for one byte.
// Depends on mbs_pkg; purely combinational, registered by the top level.
module mbs_scan_core
    import mbs_pkg::*;
#(
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
)
(
    input  byte_item_t              item,
    input  logic [OFFSET_WIDTH-1:0] pos,
    input  logic [OFFSET_WIDTH-1:0] line_begin,
    input  logic [OFFSET_WIDTH-1:0] open_start,
    input  logic [OFFSET_WIDTH-1:0] last_end,
    input  scan_mode_t              mode,
    input  line_flags_t             flags,
    output logic [OFFSET_WIDTH-1:0] pos_next,
    output logic [OFFSET_WIDTH-1:0] line_begin_next,
    output logic [OFFSET_WIDTH-1:0] open_start_next,
    output logic [OFFSET_WIDTH-1:0] last_end_next,
    output scan_mode_t              mode_next,
    output line_flags_t             flags_next,
    output logic                    emit,
    output block_item_t             emit_item
);

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    logic                    is_nl;
    logic                    is_white;
    logic                    line_done;
    logic                    fence_line;
    logic                    close_block;
    line_flags_t             flags_upd;
    logic [OFFSET_WIDTH-1:0] pos_inc;
    logic [OFFSET_WIDTH-1:0] line_end;
    logic [OFFSET_WIDTH-1:0] open_upd;
    logic [OFFSET_WIDTH-1:0] end_upd;
    scan_mode_t              mode_upd;

    always_comb
    begin
        is_nl    = (item.byte_value == CHAR_NL);
        is_white = (item.byte_value == CHAR_SPACE) || (item.byte_value == CHAR_TAB) ||
                   (item.byte_value == CHAR_CR);

        // Fold the current byte into the line flags.
        flags_upd = flags;
        if (!is_nl)
        begin
            if (!is_white)
            begin
                flags_upd.all_blank = 1'b0;
            end
            if (flags.ticks == FENCE_TICKS)
            begin
                if (!is_white)
                begin
                    flags_upd.tail_white = 1'b0;
                end
            end
            else if (flags.prefix_ok)
            begin
                if (item.byte_value == CHAR_BACKTICK)
                begin
                    flags_upd.ticks = flags.ticks + 2'd1;
                end
                else
                begin
                    flags_upd.prefix_ok = 1'b0;
                end
            end
        end

        pos_inc    = (pos == OFFSET_MAX) ? pos : pos + 1'b1;
        line_end   = is_nl ? pos : pos_inc;
        line_done  = is_nl || item.last_byte;
        fence_line = (flags_upd.ticks == FENCE_TICKS);

        open_upd    = open_start;
        end_upd     = last_end;
        mode_upd    = mode;
        close_block = 1'b0;

        if (line_done)
        begin
            case (mode)
                MODE_PLAIN:
                begin
                    if (flags_upd.all_blank)
                    begin
                        close_block = 1'b1;
                        mode_upd    = MODE_IDLE;
                    end
                    else
                    begin
                        end_upd = line_end;
                    end
                end
                MODE_FENCE:
                begin
                    end_upd = line_end;
                    if (fence_line && flags_upd.tail_white)
                    begin
                        close_block = 1'b1;
                        mode_upd    = MODE_IDLE;
                    end
                end
                default:
                begin
                    mode_upd = MODE_IDLE;
                    if (!flags_upd.all_blank)
                    begin
                        open_upd = line_begin;
                        end_upd  = line_end;
                        mode_upd = fence_line ? MODE_FENCE : MODE_PLAIN;
                    end
                end
            endcase
        end

        // A block still open at the final byte is flushed, once.
        emit = close_block || (item.last_byte && (mode_upd != MODE_IDLE));

        if (item.last_byte)
        begin
            pos_next        = '0;
            line_begin_next = '0;
            open_start_next = '0;
            last_end_next   = '0;
            mode_next       = MODE_IDLE;
            flags_next      = LINE_FLAGS_CLEAR;
        end
        else
        begin
            pos_next        = pos_inc;
            line_begin_next = line_done ? pos_inc : line_begin;
            open_start_next = open_upd;
            last_end_next   = end_upd;
            mode_next       = mode_upd;
            flags_next      = line_done ? LINE_FLAGS_CLEAR : flags_upd;
        end
    end

    // Offsets wider than the result field saturate; narrower ones zero-extend.
    generate
        if (OFFSET_WIDTH > OUT_WIDTH)
        begin : g_out_sat
            assign emit_item.block_start = (|open_upd[OFFSET_WIDTH-1:OUT_WIDTH]) ?
                                           {OUT_WIDTH{1'b1}} : open_upd[OUT_WIDTH-1:0];
            assign emit_item.block_end   = (|end_upd[OFFSET_WIDTH-1:OUT_WIDTH]) ?
                                           {OUT_WIDTH{1'b1}} : end_upd[OUT_WIDTH-1:0];
        end
        else if (OFFSET_WIDTH == OUT_WIDTH)
        begin : g_out_same
            assign emit_item.block_start = open_upd;
            assign emit_item.block_end   = end_upd;
        end
        else
        begin : g_out_ext
            assign emit_item.block_start = {{(OUT_WIDTH-OFFSET_WIDTH){1'b0}}, open_upd};
            assign emit_item.block_end   = {{(OUT_WIDTH-OFFSET_WIDTH){1'b0}}, end_upd};
        end
    endgenerate

endmodule
